@@ hw/rtl/bqli_pkg.sv @@
// Package for the biquintic Lagrange interpolator.
// Holds the payload structs, Lagrange node constants and the sequencer state type.
// No dependencies.
package bqli_pkg;

   localparam int SampleW = 32;
   localparam int FracW = 16;
   localparam int Lanes = 6;

   typedef struct packed {
      logic signed [SampleW-1:0] sample_0;
      logic signed [SampleW-1:0] sample_1;
      logic signed [SampleW-1:0] sample_2;
      logic signed [SampleW-1:0] sample_3;
      logic signed [SampleW-1:0] sample_4;
      logic signed [SampleW-1:0] sample_5;
      logic [FracW-1:0]          frac_x;
      logic [FracW-1:0]          frac_y;
      logic                      row_start;
   } req_type;

   typedef struct packed {
      logic signed [SampleW-1:0] interp_value;
      logic                      saturated;
   } rsp_type;

   // Sequencer states of the weight unit and accumulator.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WGT_Y,
      ST_ACC,
      ST_WGT_X,
      ST_MUL_X,
      ST_SUM_X,
      ST_OUT
   } state_type;

   // Node offset m-2 for m = 0..5, and the absolute Lagrange divisors.
   function automatic logic signed [2:0] node_off(input logic [2:0] m);
      logic signed [2:0] r;
      begin
         r = 3'(signed'({1'b0, m}) - 4'sd2);
         return r;
      end
   endfunction

   function automatic logic [6:0] node_div(input logic [2:0] k);
      logic [6:0] r;
      begin
         case (k)
            3'd0: r = 7'd120;
            3'd1: r = 7'd24;
            3'd2: r = 7'd12;
            3'd3: r = 7'd12;
            3'd4: r = 7'd24;
            default: r = 7'd120;
         endcase
         return r;
      end
   endfunction

   // Divisors -120, -12, -24 are negative (k = 0, 2, 4).
   function automatic logic node_neg(input logic [2:0] k);
      return ~k[0];
   endfunction

endpackage

@@ hw/rtl/biquintic_lagrange_interpolator.sv @@
// Biquintic Lagrange interpolator top level: sequencer, six weight and column lanes, merge.
// Depends on bqli_pkg, bqli_weight and bqli_column.
//
// Each transfer carries one six-sample stencil row; after the sixth row one saturated
// interpolated value is delivered. Sample and fraction widths are the package constants.
// Each accepted row passes through the y weight states (five rounded products, one
// divide and a hand-off), an accumulate state and an idle state in which the next
// row is accepted. A sixth row adds the x weights, the lane products, the merge adder
// and the output register before the next row is accepted. A result held by rsp_stall
// stalls the input until it is taken. The serial product chain inside each weight
// lane sets the length of the weight states.
module biquintic_lagrange_interpolator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bqli_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bqli_pkg::rsp_type  rsp_data
);
   import bqli_pkg::*;

   localparam int SAMPLE_WIDTH = SampleW;
   localparam int FRAC_BITS = FracW;
   localparam int TW = SAMPLE_WIDTH + 2 * FRAC_BITS + 12;
   localparam int AW = TW + 3;

   state_type state_ff, state_in;
   logic [2:0] row_ff, row_in;
   logic       last_ff, last_in;
   logic [FRAC_BITS-1:0] fx_ff, fx_in;
   logic signed [SAMPLE_WIDTH-1:0] smp_ff [Lanes];
   logic signed [AW-1:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   logic w_start;
   logic [FRAC_BITS-1:0] w_frac;
   logic [Lanes-1:0] w_done;
   logic signed [FRAC_BITS+3:0] w_val [Lanes];
   logic signed [FRAC_BITS+3:0] wy_ff;
   logic signed [FRAC_BITS+3:0] wy_in;
   logic signed [TW-1:0] term [Lanes];
   logic acc_en, mul_en;
   logic signed [AW-1:0] rounded;
   logic signed [AW-1:0] hi, lo;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);

   // Row weight is the lane of the current row index.
   always_comb begin
      wy_in = w_val[0];
      case (row_ff)
         3'd1: wy_in = w_val[1];
         3'd2: wy_in = w_val[2];
         3'd3: wy_in = w_val[3];
         3'd4: wy_in = w_val[4];
         3'd5: wy_in = w_val[5];
         default: wy_in = w_val[0];
      endcase
   end

   // Weight and column lanes.
   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      bqli_weight #(.FRAC_BITS(FRAC_BITS), .NODE(3'(g))) u_weight (
         .clock(clock), .reset(reset), .start(w_start), .frac(w_frac),
         .done(w_done[g]), .weight(w_val[g]));
      bqli_column #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_column (
         .clock(clock), .acc_en(acc_en), .first(row_ff == 3'd0),
         .sample(smp_ff[g]), .wy(wy_ff), .mul_en(mul_en), .wx(w_val[g]),
         .term(term[g]));
   end

   assign hi = AW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
   assign lo = -hi - AW'(1);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      last_in = last_ff;
      fx_in = fx_ff;
      acc_in = acc_ff;
      w_start = 1'b0;
      w_frac = req_data.frac_y[FRAC_BITS-1:0];
      acc_en = 1'b0;
      mul_en = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      rounded = (acc_ff + AW'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               w_start = 1'b1;
               if (req_data.row_start || row_ff > 3'd5) begin
                  row_in = 3'd0;
               end
               last_in = (req_data.row_start ? 3'd0 : row_ff) == 3'd5;
               fx_in = req_data.frac_x[FRAC_BITS-1:0];
               state_in = ST_WGT_Y;
            end
         end
         ST_WGT_Y: begin
            if (w_done[0]) state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_en = 1'b1;
            if (last_ff) begin
               row_in = 3'd0;
               w_start = 1'b1;
               w_frac = fx_ff;
               state_in = ST_WGT_X;
            end else begin
               row_in = row_ff + 3'd1;
               state_in = ST_IDLE;
            end
         end
         ST_WGT_X: begin
            w_frac = fx_ff;
            if (w_done[0]) state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            mul_en = 1'b1;
            state_in = ST_SUM_X;
         end
         ST_SUM_X: begin
            acc_in = AW'(term[0]) + AW'(term[1]) + AW'(term[2])
                   + AW'(term[3]) + AW'(term[4]) + AW'(term[5]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_in.saturated = (rounded > hi) || (rounded < lo);
            rsp_in.interp_value = (rounded > hi) ? SAMPLE_WIDTH'(hi)
                                : (rounded < lo) ? SAMPLE_WIDTH'(lo)
                                : SAMPLE_WIDTH'(rounded);
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      fx_ff <= fx_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
      wy_ff <= wy_in;
      if (accept) begin
         smp_ff[0] <= req_data.sample_0;
         smp_ff[1] <= req_data.sample_1;
         smp_ff[2] <= req_data.sample_2;
         smp_ff[3] <= req_data.sample_3;
         smp_ff[4] <= req_data.sample_4;
         smp_ff[5] <= req_data.sample_5;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ hw/rtl/bqli_weight.sv @@
// Quintic Lagrange weight lane: one per node, five rounded products then a divide.
// Depends on bqli_pkg.
module bqli_weight #(
   parameter int FRAC_BITS = 16,
   parameter logic [2:0] NODE = 3'd0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [FRAC_BITS-1:0]         frac,
   output logic                         done,
   output logic signed [FRAC_BITS+3:0]  weight
);
   import bqli_pkg::*;

   // Product magnitude stays below 2^(FRAC_BITS+7) for t in [0,1).
   localparam int PW = FRAC_BITS + 9;
   localparam int QW = PW + 8;

   // Floor division by 2d: a power-of-two shift, then a biased reciprocal multiply
   // by 15 or 3. The bias keeps the multiplier operand non-negative.
   localparam int DSH = (NODE == 3'd2 || NODE == 3'd3) ? 3 : 4;
   localparam int DB = (NODE == 3'd0 || NODE == 3'd5) ? 15 : 3;
   localparam int XW = FRAC_BITS + 10;
   localparam int RS = XW + 4;
   localparam int BIAS_EXP = FRAC_BITS + 5;
   localparam logic signed [QW-1:0] BIAS = QW'(longint'(DB) <<< BIAS_EXP);
   localparam logic [RS-1:0] RM = RS'(((64'd1 << RS) + 64'(DB) - 64'd1) / 64'(DB));

   logic signed [PW-1:0]   prod_ff, prod_in;
   logic [2:0]             step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   div_ff, div_in;
   logic [FRAC_BITS-1:0]   frac_ff, frac_in;
   logic signed [FRAC_BITS+3:0] weight_ff, weight_in;
   logic                   done_ff, done_in;
   logic signed [FRAC_BITS+3:0] factor;
   logic signed [PW+FRAC_BITS+4:0] mult;
   logic signed [PW-1:0]   rounded;
   logic signed [PW-1:0]   num;
   logic [6:0]             dv;
   logic signed [QW-1:0]   quot;

   always_comb begin
      factor = signed'({4'd0, frac_ff})
             - (signed'((FRAC_BITS+4)'(node_off(step_ff))) <<< FRAC_BITS);
      mult = (PW+FRAC_BITS+5)'(prod_ff) * (PW+FRAC_BITS+5)'(factor);
      rounded = PW'((mult + (PW+FRAC_BITS+5)'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
      dv = node_div(NODE);
      num = node_neg(NODE) ? -prod_ff : prod_ff;
      // Numerator of floor((2p + d) / 2d).
      quot = QW'((QW'(num) <<< 1) + QW'(signed'({1'b0, dv})));
   end

   // Division by twice the node divisor with floor rounding.
   logic signed [QW-1:0] qsh;
   logic [XW-1:0]        xb;
   logic [XW+RS-1:0]     qprod;
   logic signed [QW-1:0] qdiv;
   always_comb begin
      qsh = quot >>> DSH;
      xb = XW'(qsh + BIAS);
      qprod = (XW+RS)'(xb) * (XW+RS)'(RM);
      qdiv = signed'(QW'(qprod >> RS)) - QW'(longint'(1) <<< BIAS_EXP);
   end

   // Step through the five factors, skipping this lane's own node.
   always_comb begin
      prod_in = prod_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      div_in = 1'b0;
      frac_in = frac_ff;
      weight_in = weight_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = PW'(1) <<< FRAC_BITS;
         step_in = (NODE == 3'd0) ? 3'd1 : 3'd0;
         busy_in = 1'b1;
         frac_in = frac;
      end else if (busy_ff) begin
         prod_in = rounded;
         if (step_ff == 3'd5 || (step_ff == 3'd4 && NODE == 3'd5)) begin
            busy_in = 1'b0;
            div_in = 1'b1;
         end
         step_in = ((step_ff + 3'd1) == NODE) ? step_ff + 3'd2 : step_ff + 3'd1;
      end else if (div_ff) begin
         weight_in = (FRAC_BITS+4)'(qdiv);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         div_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         div_ff <= div_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      step_ff <= step_in;
      frac_ff <= frac_in;
      weight_ff <= weight_in;
   end

   assign done = done_ff;
   assign weight = weight_ff;

endmodule

@@ hw/rtl/bqli_column.sv @@
// Column lane: accumulates sample * row weight, then scales the sum by the x weight.
// Depends on bqli_pkg.
module bqli_column #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  acc_en,
   input  logic                                  first,
   input  logic signed [SAMPLE_WIDTH-1:0]        sample,
   input  logic signed [FRAC_BITS+3:0]           wy,
   input  logic                                  mul_en,
   input  logic signed [FRAC_BITS+3:0]           wx,
   output logic signed [SAMPLE_WIDTH+2*FRAC_BITS+11:0] term
);
   import bqli_pkg::*;

   localparam int SW = SAMPLE_WIDTH + FRAC_BITS + 8;
   localparam int TW = SAMPLE_WIDTH + 2 * FRAC_BITS + 12;

   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [TW-1:0] term_ff, term_in;
   logic signed [SW-FRAC_BITS-1:0] rsum;

   always_comb begin
      sum_in = sum_ff;
      if (acc_en) begin
         sum_in = (first ? SW'(0) : sum_ff) + SW'(sample) * SW'(wy);
      end
      rsum = (SW-FRAC_BITS)'((sum_ff + SW'(1 <<< (FRAC_BITS-1))) >>> FRAC_BITS);
      term_in = term_ff;
      if (mul_en) begin
         term_in = TW'(rsum) * TW'(wx);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule
